FILE: hdl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Types, calendar tables and small arithmetic helpers for the calendar to
// seconds converter.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam logic [16:0] SecPerDay   = 17'd86400;
  localparam logic [9:0]  EpochOffset = 10'd70;     // 1970 - 1900
  localparam logic [7:0]  CentSkip    = 8'd131;     // 2101 - 1970; 2100 not leap

  typedef struct packed {
    logic signed [5:0] q;
    logic [5:0]        r;
  } div60_t;

  typedef struct packed {
    logic signed [6:0] q;
    logic [4:0]        r;
  } div24_t;

  typedef struct packed {
    logic signed [4:0] q;
    logic [3:0]        r;
  } div12_t;

  typedef struct packed {
    logic signed [9:0]  y;
    logic signed [10:0] d;
  } yd_t;

  // Floor division by 60 for values in -521..519, by reciprocal multiplication.
  function automatic div60_t div60(input logic signed [10:0] x);
    logic [10:0] u;
    logic [21:0] p;
    logic [4:0]  q0;
    logic [10:0] rem;
    div60_t      res;
    u       = x + 11'd540;
    p       = 22'(u) * 22'd1093;
    q0      = p[20:16];
    rem     = u - 11'(q0) * 11'd60;
    res.r   = rem[5:0];
    res.q   = $signed({1'b0, q0}) - 6'sd9;
    return res;
  endfunction

  // Floor division by 24 for values in -528..1000.
  function automatic div24_t div24(input logic signed [10:0] x);
    logic [10:0] u;
    logic [22:0] p;
    logic [5:0]  q0;
    logic [10:0] rem;
    div24_t      res;
    u       = x + 11'd528;
    p       = 23'(u) * 23'd2731;
    q0      = p[21:16];
    rem     = u - 11'(q0) * 11'd24;
    res.r   = rem[4:0];
    res.q   = $signed({1'b0, q0}) - 7'sd22;
    return res;
  endfunction

  // Floor division by 12 for values in -64..63.
  function automatic div12_t div12(input logic signed [6:0] x);
    logic [7:0]  u;
    logic [20:0] p;
    logic [3:0]  q0;
    logic [7:0]  rem;
    div12_t      res;
    u       = 8'(x) + 8'd72;
    p       = 21'(u) * 21'd5462;
    q0      = p[19:16];
    rem     = u - 8'(q0) * 8'd12;
    res.r   = rem[3:0];
    res.q   = $signed({1'b0, q0}) - 5'sd6;
    return res;
  endfunction

  // Leap rule for years 1892..2162 given as an offset from 1900.
  function automatic logic is_leap(input logic signed [9:0] y);
    return (y[1:0] == 2'b00) && (y != 10'sd0) && (y != 10'sd200);
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  // Days in the year before the first day of the given month.
  function automatic logic [8:0] cum_days(input logic [3:0] mon, input logic leap);
    logic [8:0] c;
    case (mon)
      4'd0:    c = 9'd0;
      4'd1:    c = 9'd31;
      4'd2:    c = 9'd59;
      4'd3:    c = 9'd90;
      4'd4:    c = 9'd120;
      4'd5:    c = 9'd151;
      4'd6:    c = 9'd181;
      4'd7:    c = 9'd212;
      4'd8:    c = 9'd243;
      4'd9:    c = 9'd273;
      4'd10:   c = 9'd304;
      default: c = 9'd334;
    endcase
    if (leap && (mon >= 4'd2)) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

  // Moves a day offset by one year toward the range of its year.
  function automatic yd_t year_step(input yd_t a);
    yd_t               b;
    logic signed [9:0] yp;
    logic signed [10:0] len_cur;
    logic signed [10:0] len_prev;
    b        = a;
    yp       = a.y - 10'sd1;
    len_cur  = $signed({2'b00, year_len(is_leap(a.y))});
    len_prev = $signed({2'b00, year_len(is_leap(yp))});
    if (a.d < 11'sd0) begin
      b.y = yp;
      b.d = a.d + len_prev;
    end else if (a.d >= len_cur) begin
      b.y = a.y + 10'sd1;
      b.d = a.d - len_cur;
    end
    return b;
  endfunction

endpackage

FILE: hdl/calendar_to_unix_seconds.sv
// ----------------------------------------------------------------------------
// calendar_to_unix_seconds
// Normalizes a broken-down date and time and converts it to seconds since
// 1970-01-01 00:00:00.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall) carries one broken-down time per
// item; each field may be out of range or negative. The result channel
// (out_valid, out_stall) returns one item per input item, in order: the
// normalized fields, day of year, weekday, the 32-bit epoch count and the
// invalid flag. An item is accepted at a rising edge where valid is high and
// stall is low.
// The item passes seven register stages (carries, day offset, year fix-up,
// month lookup, day-to-second multiply, final add and overflow check), and
// the first of them is loaded at the accepting edge itself. One item can
// enter in every cycle while the receiver does not stall, so the sustained
// rate is then one item per cycle.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises; nothing is lost or repeated. A synchronous reset (rst_n
// low) empties the pipeline; the block takes items on the next cycle.
// Years before 1970 and counts beyond 32 bits give invalid set and an
// all-ones count; before 1970 the day of year and weekday read as zero.
// ----------------------------------------------------------------------------
module calendar_to_unix_seconds
  import cts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [9:0] in_sec_in,
  input  logic signed [9:0] in_min_in,
  input  logic signed [9:0] in_hour_in,
  input  logic signed [9:0] in_mday_in,
  input  logic signed [6:0] in_mon_in,
  input  logic [7:0]        in_year_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_epoch_seconds,
  output logic              out_invalid,
  output logic [5:0]        out_sec_out,
  output logic [5:0]        out_min_out,
  output logic [4:0]        out_hour_out,
  output logic [4:0]        out_mday_out,
  output logic [3:0]        out_mon_out,
  output logic signed [9:0] out_year_out,
  output logic [8:0]        out_yday_out,
  output logic [2:0]        out_wday_out
);

  // The pipeline moves as a whole unless a finished result is held up.
  logic en;
  logic [6:0] v_r;
  logic [6:0] v_nxt;

  assign en       = !(v_r[6] && out_stall);
  assign in_stall = v_r[6] && out_stall;
  assign v_nxt    = {v_r[5:0], in_valid};

  // Stage 1: seconds carry into minutes, months carry into years.
  div60_t              ds;
  div12_t              dmo;
  logic [5:0]          s1_sec_r;
  logic signed [10:0]  s1_min_r;
  logic signed [9:0]   s1_hour_r;
  logic signed [9:0]   s1_mday_r;
  logic [3:0]          s1_mon_r;
  logic signed [9:0]   s1_year_r;

  assign ds  = div60(11'(in_sec_in));
  assign dmo = div12(in_mon_in);

  // Stage 2: minutes carry into hours.
  div60_t              dm;
  logic [5:0]          s2_sec_r;
  logic [5:0]          s2_min_r;
  logic signed [10:0]  s2_hour_r;
  logic signed [9:0]   s2_mday_r;
  logic [3:0]          s2_mon_r;
  logic signed [9:0]   s2_year_r;

  assign dm = div60(s1_min_r);

  // Stage 3: hours carry into days; day offset from the start of the year.
  div24_t              dh;
  logic signed [10:0]  day_nxt;
  logic signed [10:0]  doy_nxt;
  logic [5:0]          s3_sec_r;
  logic [5:0]          s3_min_r;
  logic [4:0]          s3_hour_r;
  logic signed [10:0]  s3_doy_r;
  logic signed [9:0]   s3_year_r;

  assign dh      = div24(s2_hour_r);
  assign day_nxt = 11'(dh.q) + 11'(s2_mday_r) - 11'sd1;
  assign doy_nxt = $signed({2'b00, cum_days(s2_mon_r, is_leap(s2_year_r))}) + day_nxt;

  // Stage 4: at most two year steps bring the offset into its year.
  yd_t                 yd0;
  yd_t                 yd1;
  yd_t                 yd2;
  logic [5:0]          s4_sec_r;
  logic [5:0]          s4_min_r;
  logic [4:0]          s4_hour_r;
  logic [8:0]          s4_yday_r;
  logic signed [9:0]   s4_year_r;

  assign yd0 = '{y: s3_year_r, d: s3_doy_r};
  assign yd1 = year_step(yd0);
  assign yd2 = year_step(yd1);

  // Stage 5: month and day of month from the day of year; day count.
  logic                leap4;
  logic [3:0]          mon_nxt;
  logic [4:0]          mday_nxt;
  logic [7:0]          k_nxt;
  logic [5:0]          leaps_nxt;
  logic [8:0]          k_inc;
  logic [16:0]         days_nxt;
  logic                early_nxt;
  logic [5:0]          s5_sec_r;
  logic [5:0]          s5_min_r;
  logic [4:0]          s5_hour_r;
  logic [4:0]          s5_mday_r;
  logic [3:0]          s5_mon_r;
  logic signed [9:0]   s5_year_r;
  logic [8:0]          s5_yday_r;
  logic [16:0]         s5_days_r;
  logic                s5_early_r;

  assign leap4 = is_leap(s4_year_r);

  always_comb begin
    mon_nxt = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (s4_yday_r >= cum_days(4'(m), leap4)) begin
        mon_nxt = mon_nxt + 4'd1;
      end
    end
  end

  assign mday_nxt  = 5'(s4_yday_r - cum_days(mon_nxt, leap4) + 9'd1);
  assign early_nxt = s4_year_r < $signed(EpochOffset);
  assign k_nxt     = 8'(s4_year_r - $signed(EpochOffset));
  // Leap years from 1970 up to the year before; 2100 is skipped.
  assign k_inc     = 9'(k_nxt) + 9'd1;
  assign leaps_nxt = 6'(k_inc >> 2) - {5'd0, (k_nxt >= CentSkip)};
  assign days_nxt  = 17'(k_nxt) * 17'd365 + 17'(leaps_nxt) + 17'(s4_yday_r);

  // Stage 6: day count to seconds, time of day, weekday.
  logic [16:0]         wx;
  logic [5:0]          ws1;
  logic [3:0]          ws2;
  logic [2:0]          wday_nxt;
  logic [33:0]         prod_nxt;
  logic [16:0]         hms_nxt;
  logic [5:0]          s6_sec_r;
  logic [5:0]          s6_min_r;
  logic [4:0]          s6_hour_r;
  logic [4:0]          s6_mday_r;
  logic [3:0]          s6_mon_r;
  logic signed [9:0]   s6_year_r;
  logic [8:0]          s6_yday_r;
  logic [2:0]          s6_wday_r;
  logic [33:0]         s6_prod_r;
  logic [16:0]         s6_hms_r;
  logic                s6_early_r;

  // 1970-01-01 was a Thursday. Modulo 7 by summing octal digits, since 8 is 1 mod 7.
  assign wx  = s5_days_r + 17'd4;
  assign ws1 = 6'(wx[2:0]) + 6'(wx[5:3]) + 6'(wx[8:6]) + 6'(wx[11:9])
             + 6'(wx[14:12]) + 6'(wx[16:15]);
  assign ws2 = 4'(ws1[5:3]) + 4'(ws1[2:0]);
  assign wday_nxt = (ws2 >= 4'd7) ? 3'(ws2 - 4'd7) : ws2[2:0];

  assign prod_nxt = 34'(s5_days_r) * 34'(SecPerDay);
  assign hms_nxt  = 17'(s5_hour_r) * 17'd3600 + 17'(s5_min_r) * 17'd60 + 17'(s5_sec_r);

  // Stage 7: final sum and overflow check into the output register.
  logic [34:0]         total_nxt;
  logic                ovf_nxt;
  logic [31:0]         epoch_r;
  logic                invalid_r;
  logic [5:0]          sec_r;
  logic [5:0]          min_r;
  logic [4:0]          hour_r;
  logic [4:0]          mday_r;
  logic [3:0]          mon_r;
  logic signed [9:0]   year_r;
  logic [8:0]          yday_r;
  logic [2:0]          wday_r;

  assign total_nxt = 35'(s6_prod_r) + 35'(s6_hms_r);
  assign ovf_nxt   = |total_nxt[34:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sec_r   <= ds.r;
      s1_min_r   <= 11'(in_min_in) + 11'(ds.q);
      s1_hour_r  <= in_hour_in;
      s1_mday_r  <= in_mday_in;
      s1_mon_r   <= dmo.r;
      s1_year_r  <= $signed({2'b00, in_year_in}) + 10'(dmo.q);

      s2_sec_r   <= s1_sec_r;
      s2_min_r   <= dm.r;
      s2_hour_r  <= 11'(s1_hour_r) + 11'(dm.q);
      s2_mday_r  <= s1_mday_r;
      s2_mon_r   <= s1_mon_r;
      s2_year_r  <= s1_year_r;

      s3_sec_r   <= s2_sec_r;
      s3_min_r   <= s2_min_r;
      s3_hour_r  <= dh.r;
      s3_doy_r   <= doy_nxt;
      s3_year_r  <= s2_year_r;

      s4_sec_r   <= s3_sec_r;
      s4_min_r   <= s3_min_r;
      s4_hour_r  <= s3_hour_r;
      s4_yday_r  <= yd2.d[8:0];
      s4_year_r  <= yd2.y;

      s5_sec_r   <= s4_sec_r;
      s5_min_r   <= s4_min_r;
      s5_hour_r  <= s4_hour_r;
      s5_mday_r  <= mday_nxt;
      s5_mon_r   <= mon_nxt;
      s5_year_r  <= s4_year_r;
      s5_yday_r  <= s4_yday_r;
      s5_days_r  <= days_nxt;
      s5_early_r <= early_nxt;

      s6_sec_r   <= s5_sec_r;
      s6_min_r   <= s5_min_r;
      s6_hour_r  <= s5_hour_r;
      s6_mday_r  <= s5_mday_r;
      s6_mon_r   <= s5_mon_r;
      s6_year_r  <= s5_year_r;
      s6_yday_r  <= s5_early_r ? 9'd0 : s5_yday_r;
      s6_wday_r  <= s5_early_r ? 3'd0 : wday_nxt;
      s6_prod_r  <= prod_nxt;
      s6_hms_r   <= hms_nxt;
      s6_early_r <= s5_early_r;

      epoch_r    <= (s6_early_r || ovf_nxt) ? 32'hFFFF_FFFF : total_nxt[31:0];
      invalid_r  <= s6_early_r || ovf_nxt;
      sec_r      <= s6_sec_r;
      min_r      <= s6_min_r;
      hour_r     <= s6_hour_r;
      mday_r     <= s6_mday_r;
      mon_r      <= s6_mon_r;
      year_r     <= s6_year_r;
      yday_r     <= s6_yday_r;
      wday_r     <= s6_wday_r;
    end
  end

  assign out_valid         = v_r[6];
  assign out_epoch_seconds = epoch_r;
  assign out_invalid       = invalid_r;
  assign out_sec_out       = sec_r;
  assign out_min_out       = min_r;
  assign out_hour_out      = hour_r;
  assign out_mday_out      = mday_r;
  assign out_mon_out       = mon_r;
  assign out_year_out      = year_r;
  assign out_yday_out      = yday_r;
  assign out_wday_out      = wday_r;

  // A delivered time of day is always in range.
  a_hms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sec_out < 6'd60 && out_min_out < 6'd60 && out_hour_out < 5'd24))
    else $error("time of day out of range");

  // A delivered date is always in range.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mon_out < 4'd12 && out_mday_out != 5'd0 && out_wday_out < 3'd7))
    else $error("date out of range");

  // A flagged result carries the all-ones count.
  a_invalid_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (out_epoch_seconds == 32'hFFFF_FFFF))
    else $error("invalid result without all-ones count");

endmodule

FILE: bench/calendar_to_unix_seconds_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_to_unix_seconds_test
// Drives broken-down times into the converter, both well-formed and far out
// of range, and compares every returned item field by field against a
// behavioral calendar model kept in this bench. Both sides idle at random.
// ----------------------------------------------------------------------------
module calendar_to_unix_seconds_test;

  // One returned item, at the widths of the result ports.
  typedef struct packed {
    logic [31:0]       epoch_seconds;
    logic              invalid;
    logic [5:0]        sec;
    logic [5:0]        min;
    logic [4:0]        hour;
    logic [4:0]        mday;
    logic [3:0]        mon;
    logic signed [9:0] year;
    logic [8:0]        yday;
    logic [2:0]        wday;
  } time_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic signed [9:0] in_sec_in;
  logic signed [9:0] in_min_in;
  logic signed [9:0] in_hour_in;
  logic signed [9:0] in_mday_in;
  logic signed [6:0] in_mon_in;
  logic [7:0]        in_year_in;
  logic              out_valid;
  logic              out_stall;
  logic [31:0]       out_epoch_seconds;
  logic              out_invalid;
  logic [5:0]        out_sec_out;
  logic [5:0]        out_min_out;
  logic [4:0]        out_hour_out;
  logic [4:0]        out_mday_out;
  logic [3:0]        out_mon_out;
  logic signed [9:0] out_year_out;
  logic [8:0]        out_yday_out;
  logic [2:0]        out_wday_out;

  // Results still owed by the block, oldest first.
  time_result_t pending_times[$];
  int           error_count;
  // Set for the tail of the run, where neither side idles.
  bit           quiet;

  calendar_to_unix_seconds u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sec_in         (in_sec_in),
    .in_min_in         (in_min_in),
    .in_hour_in        (in_hour_in),
    .in_mday_in        (in_mday_in),
    .in_mon_in         (in_mon_in),
    .in_year_in        (in_year_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_epoch_seconds (out_epoch_seconds),
    .out_invalid       (out_invalid),
    .out_sec_out       (out_sec_out),
    .out_min_out       (out_min_out),
    .out_hour_out      (out_hour_out),
    .out_mday_out      (out_mday_out),
    .out_mon_out       (out_mon_out),
    .out_year_out      (out_year_out),
    .out_yday_out      (out_yday_out),
    .out_wday_out      (out_wday_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gregorian leap rule on a full year number.
  function automatic bit leap_year(input int full_year);
    return (full_year % 4 == 0) && ((full_year % 100 != 0) || (full_year % 400 == 0));
  endfunction

  function automatic int month_days(input int mon, input int full_year);
    case (mon)
      1:             return leap_year(full_year) ? 29 : 28;
      3, 5, 8, 10:   return 30;
      default:       return 31;
    endcase
  endfunction

  // Leap years in 1..n for n >= 0.
  function automatic longint leaps_through(input longint n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  // Normalizes the fields and converts them to seconds since 1970.
  // Division truncates toward zero, and a negative remainder borrows from
  // the next larger unit, which gives the floor division of the block.
  function automatic time_result_t calendar_seconds(
    input logic signed [9:0] sec_f, input logic signed [9:0] min_f,
    input logic signed [9:0] hour_f, input logic signed [9:0] mday_f,
    input logic signed [6:0] mon_f, input logic [7:0] year_f);
    int           sec, min, hour, mday, mon, year, day, yday, wday, full;
    longint       days, total;
    bit           bad;
    time_result_t r;
    sec  = sec_f;
    min  = min_f;
    hour = hour_f;
    mday = mday_f;
    mon  = mon_f;
    year = int'(year_f);
    yday = 0;
    wday = 0;
    bad  = 1'b0;
    total = 0;

    min += sec / 60;
    sec %= 60;
    if (sec < 0) begin
      sec += 60;
      min--;
    end
    hour += min / 60;
    min %= 60;
    if (min < 0) begin
      min += 60;
      hour--;
    end
    day = hour / 24;
    hour %= 24;
    if (hour < 0) begin
      hour += 24;
      day--;
    end
    year += mon / 12;
    mon %= 12;
    if (mon < 0) begin
      mon += 12;
      year--;
    end

    // Walk whole months until the day offset falls inside its month.
    day += mday - 1;
    while (day < 0) begin
      mon--;
      if (mon < 0) begin
        mon = 11;
        year--;
      end
      day += month_days(mon, 1900 + year);
    end
    while (day >= month_days(mon, 1900 + year)) begin
      day -= month_days(mon, 1900 + year);
      mon++;
      if (mon == 12) begin
        mon = 0;
        year++;
      end
    end
    mday = day + 1;

    if (year < 70) begin
      // Before the epoch: no count, and day of year and weekday read zero.
      bad = 1'b1;
    end else begin
      full = year + 1900;
      days = longint'(full - 1970) * 365 + leaps_through(full - 1) - leaps_through(1969);
      for (int m = 0; m < mon; m++) begin
        yday += month_days(m, full);
      end
      yday += mday - 1;
      days += yday;
      wday = int'((days + 4) % 7);
      total = days * 86400 + longint'((hour * 60 + min) * 60 + sec);
      if (total > 64'hFFFF_FFFF) begin
        bad = 1'b1;
      end
    end

    r.epoch_seconds = bad ? 32'hFFFF_FFFF : total[31:0];
    r.invalid       = bad;
    r.sec           = sec[5:0];
    r.min           = min[5:0];
    r.hour          = hour[4:0];
    r.mday          = mday[4:0];
    r.mon           = mon[3:0];
    r.year          = year[9:0];
    r.yday          = yday[8:0];
    r.wday          = wday[2:0];
    return r;
  endfunction

  // Presents one item and holds it until the block takes it. The stall is
  // sampled at the falling edge, where it is settled for the coming rising
  // edge. A random idle gap may come first, except when quiet.
  task automatic send_time(input logic signed [9:0] sec_f, input logic signed [9:0] min_f,
                           input logic signed [9:0] hour_f, input logic signed [9:0] mday_f,
                           input logic signed [6:0] mon_f, input logic [7:0] year_f);
    bit stalled;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_sec_in  <= sec_f;
    in_min_in  <= min_f;
    in_hour_in <= hour_f;
    in_mday_in <= mday_f;
    in_mon_in  <= mon_f;
    in_year_in <= year_f;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    pending_times.push_back(calendar_seconds(sec_f, min_f, hour_f, mday_f, mon_f, year_f));
  endtask

  // Receiver side: random stall bursts, none when quiet.
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left > 0);
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // A result is taken at the next rising edge when it is valid and not
  // stalled at this falling edge; compare it against the oldest prediction.
  always @(negedge clk) begin
    time_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_times.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected, actual seconds %h", $time,
                 out_epoch_seconds);
      end else begin
        want = pending_times.pop_front();
        if (want.epoch_seconds !== out_epoch_seconds || want.invalid !== out_invalid ||
            want.sec !== out_sec_out || want.min !== out_min_out ||
            want.hour !== out_hour_out || want.mday !== out_mday_out ||
            want.mon !== out_mon_out || want.year !== out_year_out ||
            want.yday !== out_yday_out || want.wday !== out_wday_out) begin
          error_count++;
          $display("%0t: mismatch expected secs=%h inv=%b %0d:%0d:%0d d=%0d m=%0d y=%0d yd=%0d wd=%0d",
                   $time, want.epoch_seconds, want.invalid, want.hour, want.min, want.sec,
                   want.mday, want.mon, want.year, want.yday, want.wday);
          $display("%0t:          actual   secs=%h inv=%b %0d:%0d:%0d d=%0d m=%0d y=%0d yd=%0d wd=%0d",
                   $time, out_epoch_seconds, out_invalid, out_hour_out, out_min_out,
                   out_sec_out, out_mday_out, out_mon_out, out_year_out, out_yday_out,
                   out_wday_out);
        end
      end
    end
  end

  // Field extremes, the epoch, the leap rules and both error cases.
  task automatic test_directed();
    send_time(10'sd0, 10'sd0, 10'sd0, 10'sd1, 7'sd0, 8'd70);        // the epoch itself
    send_time(-10'sd1, 10'sd0, 10'sd0, 10'sd1, 7'sd0, 8'd70);       // one second before it
    send_time(10'sd59, 10'sd59, 10'sd23, 10'sd31, 7'sd11, 8'd69);   // last second of 1969
    send_time(10'sd511, 10'sd511, 10'sd511, 10'sd511, 7'sd63, 8'd255);
    send_time(-10'sd512, -10'sd512, -10'sd512, -10'sd512, -7'sd64, 8'd0);
    send_time(-10'sd512, -10'sd512, -10'sd512, -10'sd512, -7'sd64, 8'd255);
    send_time(10'sd511, 10'sd511, 10'sd511, 10'sd511, 7'sd63, 8'd0);
    send_time(10'sd7, 10'sd14, 10'sd3, 10'sd19, 7'sd0, 8'd138);     // 2038 rollover point
    send_time(10'sd8, 10'sd14, 10'sd3, 10'sd19, 7'sd0, 8'd138);
    send_time(10'sd15, 10'sd28, 10'sd6, 10'sd7, 7'sd1, 8'd206);     // largest count
    send_time(10'sd16, 10'sd28, 10'sd6, 10'sd7, 7'sd1, 8'd206);     // just past it
    send_time(10'sd0, 10'sd0, 10'sd0, 10'sd29, 7'sd1, 8'd100);      // leap day of 2000
    send_time(10'sd0, 10'sd0, 10'sd0, 10'sd29, 7'sd1, 8'd200);      // 2100 has none
    send_time(10'sd0, 10'sd0, 10'sd0, 10'sd29, 7'sd1, 8'd72);
    send_time(10'sd0, 10'sd0, 10'sd0, 10'sd29, 7'sd1, 8'd73);
    send_time(10'sd0, 10'sd0, 10'sd0, 10'sd0, 7'sd0, 8'd71);        // day zero borrows a year
    send_time(10'sd0, 10'sd0, -10'sd1, 10'sd1, 7'sd0, 8'd101);
    send_time(10'sd30, 10'sd30, 10'sd12, 10'sd31, 7'sd11, 8'd100);  // last day of a leap year
    send_time(10'sd0, 10'sd0, 10'sd0, 10'sd1, -7'sd1, 8'd71);       // negative month
    send_time(10'sd0, 10'sd0, 10'sd0, 10'sd1, 7'sd12, 8'd70);       // month carries a year
    send_time(10'sd60, 10'sd60, 10'sd24, 10'sd32, 7'sd0, 8'd80);    // sec to mday one too far
  endtask

  // Mostly in-range dates near the valid span, with some fields nudged out.
  task automatic test_random_dates(input int count);
    logic signed [9:0] s, mi, h, d;
    logic signed [6:0] mo;
    logic [7:0]        y;
    for (int i = 0; i < count; i++) begin
      s  = 10'($urandom_range(0, 59));
      mi = 10'($urandom_range(0, 59));
      h  = 10'($urandom_range(0, 23));
      d  = 10'($urandom_range(1, 31));
      mo = 7'($urandom_range(0, 11));
      y  = 8'($urandom_range(68, 208));
      if ($urandom_range(0, 3) == 0) s = s + 10'($urandom_range(0, 120)) - 10'sd60;
      if ($urandom_range(0, 3) == 0) mi = mi + 10'($urandom_range(0, 120)) - 10'sd60;
      if ($urandom_range(0, 3) == 0) h = h + 10'($urandom_range(0, 48)) - 10'sd24;
      if ($urandom_range(0, 3) == 0) d = 10'($urandom_range(0, 70)) - 10'sd20;
      if ($urandom_range(0, 4) == 0) mo = 7'($urandom_range(0, 36)) - 7'sd12;
      send_time(s, mi, h, d, mo, y);
    end
  endtask

  // Random bit patterns in every field.
  task automatic test_random_raw(input int count);
    for (int i = 0; i < count; i++) begin
      send_time(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                7'($urandom), 8'($urandom));
    end
  endtask

  // Back-to-back items with the receiver never stalling.
  task automatic test_full_rate(input int count);
    quiet = 1'b1;
    test_random_dates(count / 2);
    test_random_raw(count - count / 2);
  endtask

  initial begin
    error_count = 0;
    quiet       = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_sec_in   = '0;
    in_min_in   = '0;
    in_hour_in  = '0;
    in_mday_in  = '0;
    in_mon_in   = '0;
    in_year_in  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_dates(600);
    test_random_raw(230);
    test_full_rate(100);
    in_valid <= 1'b0;

    while (pending_times.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_times.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
hdl/cts_pkg.sv
hdl/calendar_to_unix_seconds.sv
bench/calendar_to_unix_seconds_test.sv
